// ===== rtl/hte_pkg.sv =====
// Shared types and constants of the table-driven Huffman encoder.
package hte_pkg;

  // Field widths fixed by the interface
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned CODE_W  = 15;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TOTAL_W = 24;

  // Bit packer sizes: up to 7 pending bits plus one full-length code
  localparam int unsigned PEND_W  = 7;
  localparam int unsigned PCNT_W  = 3;
  localparam int unsigned ACC_W   = PEND_W + CODE_W;
  localparam int unsigned NBITS_W = $clog2(ACC_W + 1);

  // Table entry: code bits over length
  localparam int unsigned ENTRY_W = CODE_W + LEN_W;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic tbl_write;    // write the table entry of the accepted word
    logic tbl_read;     // start the table lookup of the accepted word
    logic flush;        // emit the final byte and restart the block
    logic pack;         // merge the looked-up code into the packer
    logic send_second;  // move the held second byte to the output
  } hte_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;     // output register empty or being taken this cycle
    logic two_bytes;    // the current code completes two bytes
  } hte_status_t;

endpackage

// ===== rtl/hte_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hte_ram #(
  parameter int unsigned WIDTH = 19,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/hte_datapath.sv =====
// Datapath: code table, entry valid bits, bit packer, bit counter and output register.
module hte_datapath #(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned MAX_CODE_LEN = 15,
  parameter int unsigned COUNT_WIDTH  = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  hte_pkg::hte_cmd_t            cmd,
  output hte_pkg::hte_status_t         status,
  input  logic [hte_pkg::SYM_W-1:0]    symbol,
  input  logic [hte_pkg::CODE_W-1:0]   code_word,
  input  logic [hte_pkg::LEN_W-1:0]    code_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hte_pkg::BYTE_W-1:0]   data_byte,
  output logic                         byte_valid,
  output logic                         final_flag,
  output logic [hte_pkg::TOTAL_W-1:0]  bit_total,
  output logic                         count_overflow,
  output logic                         missing_code,
  output logic                         last
);

  localparam int unsigned ADDR_W = $clog2(SYMBOL_COUNT);
  localparam logic [hte_pkg::LEN_W-1:0] LEN_CAP =
    (MAX_CODE_LEN > 15) ? hte_pkg::LEN_W'(15) : hte_pkg::LEN_W'(MAX_CODE_LEN);
  localparam logic [hte_pkg::SYM_W:0] SYM_LIMIT = (hte_pkg::SYM_W + 1)'(SYMBOL_COUNT);

  // Table entry valid bits and lookup qualifiers
  logic [SYMBOL_COUNT-1:0]          entry_valid;
  logic                             sym_in_range;
  logic [ADDR_W-1:0]                sym_idx;
  logic                             rd_ok;

  // Table write data
  logic [hte_pkg::LEN_W-1:0]        len_clamped;
  logic [hte_pkg::CODE_W-1:0]       code_masked;
  logic [hte_pkg::ENTRY_W-1:0]      rd_entry;
  logic [hte_pkg::CODE_W-1:0]       rd_code;
  logic [hte_pkg::LEN_W-1:0]        rd_len;

  // Packer state
  logic [hte_pkg::PEND_W-1:0]       pending_bits;
  logic [hte_pkg::PEND_W-1:0]       pending_bits_next;
  logic [hte_pkg::PCNT_W-1:0]       pending_count;
  logic [COUNT_WIDTH-1:0]           bits_emitted;
  logic                             overflow_seen;
  logic [hte_pkg::BYTE_W-1:0]       second_byte;

  // Packer arithmetic
  logic [hte_pkg::LEN_W-1:0]        look_len;
  logic                             look_missing;
  logic [hte_pkg::ACC_W-1:0]        acc;
  logic [hte_pkg::NBITS_W-1:0]      nbits;
  logic [hte_pkg::BYTE_W-1:0]       byte_hi;
  logic [hte_pkg::BYTE_W-1:0]       byte_lo;
  logic                             look_emit;
  logic                             look_two;
  logic [COUNT_WIDTH:0]             count_sum;

  // Decode the table index
  assign sym_in_range = {1'b0, symbol} < SYM_LIMIT;
  assign sym_idx      = symbol[ADDR_W-1:0];

  // Clamp the length and keep only its low code bits
  assign len_clamped = (code_length > LEN_CAP) ? LEN_CAP : code_length;
  assign code_masked = code_word & ~({hte_pkg::CODE_W{1'b1}} << len_clamped);

  hte_ram #(
    .WIDTH (hte_pkg::ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (cmd.tbl_write && sym_in_range),
    .waddr (sym_idx),
    .wdata ({code_masked, len_clamped}),
    .re    (cmd.tbl_read),
    .raddr (sym_idx),
    .rdata (rd_entry)
  );

  assign rd_code = rd_entry[hte_pkg::ENTRY_W-1:hte_pkg::LEN_W];
  assign rd_len  = rd_entry[hte_pkg::LEN_W-1:0];

  // Mark written entries; unwritten entries read as having no code
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.tbl_write && sym_in_range) begin
      entry_valid[sym_idx] <= 1'b1;
    end
  end

  // Qualify the lookup alongside the registered read
  always_ff @(posedge clk) begin
    if (cmd.tbl_read) begin
      rd_ok <= sym_in_range && entry_valid[sym_idx];
    end
  end

  // Merge the code below the pending bits and pick the completed bytes
  assign look_len     = rd_ok ? rd_len : '0;
  assign look_missing = (look_len == '0);
  assign acc          = (hte_pkg::ACC_W'(pending_bits) << look_len) |
                        hte_pkg::ACC_W'(rd_code);
  assign nbits        = hte_pkg::NBITS_W'(pending_count) + hte_pkg::NBITS_W'(look_len);
  assign byte_hi      = hte_pkg::BYTE_W'(acc >> (nbits - hte_pkg::NBITS_W'(8)));
  assign byte_lo      = hte_pkg::BYTE_W'(acc >> (nbits - hte_pkg::NBITS_W'(16)));
  assign look_two     = !look_missing && (nbits >= hte_pkg::NBITS_W'(16));
  assign look_emit    = look_missing || (nbits >= hte_pkg::NBITS_W'(8));
  assign pending_bits_next = acc[hte_pkg::PEND_W-1:0] &
                             ~({hte_pkg::PEND_W{1'b1}} << nbits[hte_pkg::PCNT_W-1:0]);
  assign count_sum    = {1'b0, bits_emitted} + (COUNT_WIDTH + 1)'(look_len);

  // Advance the packer and the saturating bit count
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      bits_emitted  <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.flush) begin
      pending_bits  <= '0;
      pending_count <= '0;
      bits_emitted  <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.pack && !look_missing) begin
      pending_bits  <= pending_bits_next;
      pending_count <= nbits[hte_pkg::PCNT_W-1:0];
      if (count_sum[COUNT_WIDTH]) begin
        bits_emitted  <= '1;
        overflow_seen <= 1'b1;
      end else begin
        bits_emitted <= count_sum[COUNT_WIDTH-1:0];
      end
    end
  end

  // Hold the second completed byte until the output register frees
  always_ff @(posedge clk) begin
    if (cmd.pack) begin
      second_byte <= byte_lo;
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.flush || (cmd.pack && look_emit) || cmd.send_second) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      data_byte      <= (pending_count != '0) ? {1'b0, pending_bits} : '0;
      byte_valid     <= (pending_count != '0);
      final_flag     <= 1'b1;
      bit_total      <= hte_pkg::TOTAL_W'(bits_emitted);
      count_overflow <= overflow_seen;
      missing_code   <= 1'b0;
      last           <= 1'b1;
    end else if (cmd.pack && look_emit) begin
      data_byte      <= look_missing ? '0 : byte_hi;
      byte_valid     <= !look_missing;
      final_flag     <= 1'b0;
      bit_total      <= '0;
      count_overflow <= 1'b0;
      missing_code   <= look_missing;
      last           <= !look_two;
    end else if (cmd.send_second) begin
      data_byte      <= second_byte;
      byte_valid     <= 1'b1;
      final_flag     <= 1'b0;
      bit_total      <= '0;
      count_overflow <= 1'b0;
      missing_code   <= 1'b0;
      last           <= 1'b1;
    end
  end

  // Report to the controller
  assign status.out_free  = !out_valid || out_ready;
  assign status.two_bytes = look_two;

endmodule

// ===== rtl/hte_ctrl.sv =====
// Controller: sequences accept, table lookup, packing and second-byte delivery.
module hte_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [hte_pkg::REQ_W-1:0] req_type,
  input  hte_pkg::hte_status_t      status,
  output hte_pkg::hte_cmd_t         cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PACK   = 2'd1;
  localparam logic [1:0] S_SECOND = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  // Take a word only when idle and the output register can take a result
  assign in_ready = (state == S_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req_type)
            hte_pkg::REQ_LOAD: begin
              cmd.tbl_write = 1'b1;
            end
            hte_pkg::REQ_ENCODE: begin
              cmd.tbl_read = 1'b1;
              state_next   = S_PACK;
            end
            hte_pkg::REQ_FLUSH: begin
              cmd.flush = 1'b1;
            end
            default: begin
              // unused request: drop
            end
          endcase
        end
      end
      S_PACK: begin
        cmd.pack   = 1'b1;
        state_next = status.two_bytes ? S_SECOND : S_IDLE;
      end
      S_SECOND: begin
        if (status.out_free) begin
          cmd.send_second = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/huffman_table_encoder_core.sv =====
// Top level of the table-driven Huffman encoder: controller plus datapath.
//
// Load words write one code table entry. Encode words first do the registered
// read of the code table and then merge the code into the bit packer; a code
// that completes two bytes holds the block in the second-byte state to hand
// over the second byte once the output register frees. Flush words return the
// tail byte with the block's bit count. A word is taken only while idle and the
// output register is empty or being drained, so back-pressure on the result
// side stalls the input. The table needs no clearing pass after reset: a valid
// bit per entry makes every unwritten symbol read as having no code, so words
// are taken as soon as reset ends.
module huffman_table_encoder_core #(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned MAX_CODE_LEN = 15,
  parameter int unsigned COUNT_WIDTH  = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hte_pkg::REQ_W-1:0]    req_type,
  input  logic [hte_pkg::SYM_W-1:0]    symbol,
  input  logic [hte_pkg::CODE_W-1:0]   code_word,
  input  logic [hte_pkg::LEN_W-1:0]    code_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hte_pkg::BYTE_W-1:0]   data_byte,
  output logic                         byte_valid,
  output logic                         final_flag,
  output logic [hte_pkg::TOTAL_W-1:0]  bit_total,
  output logic                         count_overflow,
  output logic                         missing_code,
  output logic                         last
);

  hte_pkg::hte_cmd_t    cmd;
  hte_pkg::hte_status_t status;

  hte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  hte_datapath #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .symbol         (symbol),
    .code_word      (code_word),
    .code_length    (code_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .final_flag     (final_flag),
    .bit_total      (bit_total),
    .count_overflow (count_overflow),
    .missing_code   (missing_code),
    .last           (last)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the table-driven Huffman encoder core.
module testbench;
  import hte_pkg::*;

  localparam int unsigned SYMS   = 256;
  localparam int unsigned MAXLEN = 15;
  // Bit count width of the core under test
  localparam int unsigned CNT_W   = 16;
  localparam longint      CNT_MAX = (64'd1 << CNT_W) - 1;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               byte_ok;
    logic               fin;
    logic [TOTAL_W-1:0] total;
    logic               ovf;
    logic               miss;
    logic               lst;
  } enc_result_t;

  // Bit packer prediction and in-order matching of output words
  class packer_scoreboard;
    int          tbl_code[SYMS];
    int          tbl_len[SYMS];
    int          tail_bits;
    int          tail_cnt;
    longint      block_bits;
    bit          block_sat;
    enc_result_t due_results[$];
    int          fails, checked, n_bytes, n_final, n_miss, n_sat;

    function new();
      foreach (tbl_len[i]) begin
        tbl_len[i]  = 0;
        tbl_code[i] = 0;
      end
      tail_bits  = 0;
      tail_cnt   = 0;
      block_bits = 0;
      block_sat  = 1'b0;
      fails      = 0;
      checked    = 0;
      n_bytes    = 0;
      n_final    = 0;
      n_miss     = 0;
      n_sat      = 0;
    endfunction

    // Note an accepted input word and queue the words it must produce
    function void take_word(logic [REQ_W-1:0] req, logic [SYM_W-1:0] sym,
                            logic [CODE_W-1:0] word, logic [LEN_W-1:0] len);
      int          s;
      int          l;
      int          acc;
      int          n;
      enc_result_t r;
      s = sym;
      case (req)
        REQ_LOAD: begin
          if (s < SYMS) begin
            l = (len > MAXLEN) ? MAXLEN : len;
            tbl_len[s]  = l;
            tbl_code[s] = (l == 0) ? 0 : (int'(word) & ((1 << l) - 1));
          end
        end
        REQ_ENCODE: begin
          r = '0;
          if (s >= SYMS || tbl_len[s] == 0) begin
            r.miss = 1'b1;
            r.lst  = 1'b1;
            due_results = {due_results, r};
          end else begin
            l   = tbl_len[s];
            acc = (tail_bits << l) | tbl_code[s];
            n   = tail_cnt + l;
            if (CNT_MAX - block_bits < l) begin
              block_bits = CNT_MAX;
              block_sat  = 1'b1;
            end else begin
              block_bits += l;
            end
            while (n >= 8) begin
              n -= 8;
              r         = '0;
              r.data    = BYTE_W'((acc >> n) & 8'hFF);
              r.byte_ok = 1'b1;
              r.lst     = (n < 8);
              due_results = {due_results, r};
            end
            tail_cnt  = n;
            tail_bits = acc & ((1 << n) - 1);
          end
        end
        REQ_FLUSH: begin
          r         = '0;
          r.byte_ok = (tail_cnt != 0);
          r.data    = (tail_cnt != 0) ? BYTE_W'(tail_bits) : '0;
          r.fin     = 1'b1;
          r.total   = TOTAL_W'(block_bits);
          r.ovf     = block_sat;
          r.lst     = 1'b1;
          due_results = {due_results, r};
          tail_bits  = 0;
          tail_cnt   = 0;
          block_bits = 0;
          block_sat  = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // Compare an accepted output word with the oldest prediction
    function void match_result(enc_result_t got);
      enc_result_t exp_r;
      if (due_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("ERROR: extra word data=%h byte=%b fin=%b total=%0d ovf=%b miss=%b last=%b",
                   got.data, got.byte_ok, got.fin, got.total, got.ovf, got.miss, got.lst);
      end else begin
        exp_r = due_results.pop_front();
        checked++;
        if (exp_r.byte_ok && !exp_r.fin) n_bytes++;
        if (exp_r.fin) n_final++;
        if (exp_r.miss) n_miss++;
        if (exp_r.ovf) n_sat++;
        if (got.data !== exp_r.data || got.byte_ok !== exp_r.byte_ok ||
            got.fin !== exp_r.fin || got.total !== exp_r.total ||
            got.ovf !== exp_r.ovf || got.miss !== exp_r.miss || got.lst !== exp_r.lst) begin
          fails++;
          if (fails <= 10) begin
            $display("ERROR: word %0d expected data=%h byte=%b fin=%b total=%0d",
                     checked, exp_r.data, exp_r.byte_ok, exp_r.fin, exp_r.total);
            $display("       expected ovf=%b miss=%b last=%b",
                     exp_r.ovf, exp_r.miss, exp_r.lst);
            $display("       got data=%h byte=%b fin=%b total=%0d ovf=%b miss=%b last=%b",
                     got.data, got.byte_ok, got.fin, got.total, got.ovf, got.miss, got.lst);
          end
        end
      end
    endfunction

    function int waiting();
      return due_results.size();
    endfunction
  endclass

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               out_ready   = 1'b0;
  logic [REQ_W-1:0]   req_type    = REQ_LOAD;
  logic [SYM_W-1:0]   symbol      = '0;
  logic [CODE_W-1:0]  code_word   = '0;
  logic [LEN_W-1:0]   code_length = '0;
  logic               in_ready;
  logic               out_valid;
  logic [BYTE_W-1:0]  data_byte;
  logic               byte_valid;
  logic               final_flag;
  logic [TOTAL_W-1:0] bit_total;
  logic               count_overflow;
  logic               missing_code;
  logic               last;

  bit               calm      = 1'b0;
  bit               hold_sink = 1'b0;
  int               sink_gap  = 0;
  int               words_sent = 0;
  enc_result_t      got_r;
  packer_scoreboard sb;

  huffman_table_encoder_core #(
    .SYMBOL_COUNT (SYMS),
    .MAX_CODE_LEN (MAXLEN),
    .COUNT_WIDTH  (CNT_W)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .symbol         (symbol),
    .code_word      (code_word),
    .code_length    (code_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .final_flag     (final_flag),
    .bit_total      (bit_total),
    .count_overflow (count_overflow),
    .missing_code   (missing_code),
    .last           (last)
  );

  always #5 clk = ~clk;

  // Take output words and stall the result side in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got_r = '{data_byte, byte_valid, final_flag, bit_total, count_overflow,
                  missing_code, last};
        sb.match_result(got_r);
      end
      if (hold_sink) begin
        out_ready <= 1'b0;
      end else if (sink_gap != 0) begin
        out_ready <= 1'b0;
        sink_gap  <= sink_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        sink_gap  <= $urandom_range(0, 12);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Block the result side for a long stretch so the input backs up
  task automatic hold_sink_for(input int cycles);
    hold_sink <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_sink <= 1'b0;
  endtask

  // Offer one input word, maybe after an idle burst, and wait for acceptance
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    symbol      <= sym;
    code_word   <= word;
    code_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_word(req, sym, word, len);
    words_sent++;
  endtask

  // Mostly encodes of loaded symbols, with loads, flushes and unused requests mixed in
  task automatic send_random_word();
    int               pick;
    logic [SYM_W-1:0] s;
    pick = $urandom_range(0, 99);
    s = ($urandom_range(0, 3) != 0) ? SYM_W'($urandom_range(0, 31)) : SYM_W'($urandom);
    if (pick < 8)
      send_word(REQ_LOAD, s, CODE_W'($urandom), LEN_W'($urandom));
    else if (pick < 84)
      send_word(REQ_ENCODE, s, CODE_W'($urandom), LEN_W'($urandom));
    else if (pick < 95)
      send_word(REQ_FLUSH, s, CODE_W'($urandom), LEN_W'($urandom));
    else
      send_word(REQ_UNUSED, s, CODE_W'($urandom), LEN_W'($urandom));
  endtask

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, empty flush, extreme codes, unused request
    send_word(REQ_ENCODE, 8'd0,   15'h0000, 4'd0);
    send_word(REQ_FLUSH,  8'd0,   15'h0000, 4'd0);
    send_word(REQ_LOAD,   8'd0,   15'h7FFF, 4'd15);
    send_word(REQ_LOAD,   8'd255, 15'h0000, 4'd1);
    send_word(REQ_LOAD,   8'd1,   15'h7FFD, 4'd3);
    send_word(REQ_LOAD,   8'd2,   15'h1234, 4'd0);
    send_word(REQ_ENCODE, 8'd0,   15'h0000, 4'd0);
    send_word(REQ_ENCODE, 8'd0,   15'h7FFF, 4'd15);
    send_word(REQ_ENCODE, 8'd255, 15'h0000, 4'd0);
    send_word(REQ_ENCODE, 8'd2,   15'h0000, 4'd0);
    send_word(REQ_ENCODE, 8'd1,   15'h0000, 4'd0);
    send_word(REQ_UNUSED, 8'hFF,  15'h7FFF, 4'hF);
    send_word(REQ_FLUSH,  8'hFF,  15'h7FFF, 4'hF);
    // Exact byte, then a flush with nothing pending but a nonzero count
    send_word(REQ_LOAD,   8'd3,   15'h00A5, 4'd8);
    send_word(REQ_ENCODE, 8'd3,   15'h0000, 4'd0);
    send_word(REQ_FLUSH,  8'd0,   15'h0000, 4'd0);
    // Drop a code again
    send_word(REQ_LOAD,   8'd0,   15'h7FFF, 4'd0);
    send_word(REQ_ENCODE, 8'd0,   15'h0000, 4'd0);
    send_word(REQ_FLUSH,  8'd0,   15'h0000, 4'd0);

    // Prime a table, then random traffic starting with a long output stall
    for (int i = 0; i < 32; i++)
      send_word(REQ_LOAD, SYM_W'(i), CODE_W'($urandom), LEN_W'($urandom_range(1, 15)));
    fork
      hold_sink_for(300);
    join_none
    repeat (360) send_random_word();

    // Run a block of maximum-length codes, then check the count clears
    send_word(REQ_FLUSH, 8'd0, 15'h0000, 4'd0);
    send_word(REQ_LOAD, 8'd200, CODE_W'($urandom), 4'd15);
    repeat (40)
      send_word(REQ_ENCODE, 8'd200, CODE_W'($urandom), LEN_W'($urandom));
    send_word(REQ_FLUSH, 8'd200, 15'h0000, 4'd0);
    send_word(REQ_ENCODE, 8'd200, 15'h0000, 4'd0);
    send_word(REQ_FLUSH, 8'd0, 15'h0000, 4'd0);

    // Final stretch with no random stalls on either side
    calm = 1'b1;
    repeat (150) send_random_word();
    send_word(REQ_FLUSH, 8'd0, 15'h0000, 4'd0);
    in_valid <= 1'b0;

    // Drain outstanding words, then allow for trailing output
    while (sb.waiting() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d words; matched %0d output words: %0d data bytes, %0d flushes,",
             words_sent, sb.checked, sb.n_bytes, sb.n_final);
    $display("%0d missing codes, %0d saturated totals; a 300-cycle output stall backed up input.",
             sb.n_miss, sb.n_sat);
    if (sb.fails == 0 && sb.waiting() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hte_pkg.sv
rtl/hte_ram.sv
rtl/hte_datapath.sv
rtl/hte_ctrl.sv
rtl/huffman_table_encoder_core.sv
dv/testbench.sv
